// ----- sv/assert_macros.svh -----
// assertion macros shared by the attribute list parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/alp_pkg.sv -----
// types and constants of the attribute list parser
package alp_pkg;

  typedef enum logic [2:0] {
    KIND_NAME_CHAR  = 3'd0,
    KIND_VALUE_CHAR = 3'd1,
    KIND_PAIR       = 3'd2,
    KIND_NO_EQ      = 3'd3,
    KIND_BAD_SEP    = 3'd4,
    KIND_LINE_END   = 3'd5
  } kind_e;

  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;

  // results one byte can cause
  localparam int RUN_MAX = 3;
  localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);
  localparam int RUN_IDX_W = $clog2(RUN_MAX);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] byte_in;
    logic       line_last;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] char_out;
    logic       run_end;
  } out_t;

  // all results of one input byte
  typedef struct packed {
    logic [RUN_CNT_W-1:0]        cnt;
    logic [RUN_MAX-1:0][2:0]     kind;
    logic [RUN_MAX-1:0][7:0]     chr;
  } run_t;

  // queue handshake: push from the front end, pop from the back end
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

endpackage

// ----- sv/attribute_list_parser_core.sv -----
// top level of the attribute list parser
//
//   channel   direction  handshake      payload
//   input     in         push / full    in_data_i  (byte_in, line_last)
//   result    out        pop / empty    out_data_o (kind, char_out, run_end)
//
// one byte is taken per cycle while the queue is not full; the phase machine decides its run in that cycle
// a byte gives zero to three results, played out one per cycle by the back end while pop is high
// a four-entry run queue sits between them; full follows the queue alone
// first result of a byte is visible once its run has passed the queue and been loaded into the back end run register
// reset clears the parse phase to awaiting a name, and empties queue and output
module attribute_list_parser_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  alp_pkg::in_t  in_data_i,
  input  logic          pop,
  output logic          empty,
  output alp_pkg::out_t out_data_o
);
  import alp_pkg::*;

  logic    accept;
  logic    run_push;
  run_t    run;
  run_t    q_data;
  logic    q_empty;
  logic    q_pop;
  q_ctrl_t q_ctrl;

  assign accept = push && !full;

  alp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .run_push_o (run_push),
    .run_o      (run)
  );

  assign q_ctrl.push = run_push;
  assign q_ctrl.pop  = q_pop;

  alp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (q_ctrl),
    .wr_data_i (run),
    .rd_data_o (q_data),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  alp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_data_i   (q_data),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_data_o (out_data_o)
  );

endmodule

// ----- sv/alp_front.sv -----
// front end: per-byte phase machine that builds the result run of each byte
module alp_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  alp_pkg::in_t in_data_i,
  output logic         run_push_o,
  output alp_pkg::run_t run_o
);
  import alp_pkg::*;

  localparam logic [2:0] PH_NAME_START  = 3'd0;
  localparam logic [2:0] PH_NAME        = 3'd1;
  localparam logic [2:0] PH_VAL_START   = 3'd2;
  localparam logic [2:0] PH_PLAIN       = 3'd3;
  localparam logic [2:0] PH_QUOTED      = 3'd4;
  localparam logic [2:0] PH_ESCAPE      = 3'd5;
  localparam logic [2:0] PH_AFTER_QUOTE = 3'd6;
  localparam logic [2:0] PH_SKIP        = 3'd7;

  logic [2:0] phase_q, phase_d;
  logic [7:0] c;
  logic       name_byte;
  logic [7:0] esc_c;
  run_t       run;

  function automatic run_t run_add(run_t r, kind_e k, logic [7:0] ch);
    r.kind[r.cnt[RUN_IDX_W-1:0]] = k;
    r.chr[r.cnt[RUN_IDX_W-1:0]]  = ch;
    r.cnt = r.cnt + RUN_CNT_W'(1);
    return r;
  endfunction

  assign c = in_data_i.byte_in;
  assign name_byte = ((c >= CH_UP_A) && (c <= CH_UP_Z)) || (c == CH_DASH);

  always_comb begin
    priority if (c == CH_LOW_R) begin
      esc_c = CH_CR;
    end else if (c == CH_LOW_N) begin
      esc_c = CH_LF;
    end else begin
      esc_c = c;
    end
  end

  always_comb begin
    run     = '0;
    phase_d = phase_q;
    unique case (phase_q)
      PH_NAME_START, PH_NAME: begin
        if (name_byte) begin
          run     = run_add(run, KIND_NAME_CHAR, c);
          phase_d = PH_NAME;
        end else if (c == CH_EQ) begin
          phase_d = PH_VAL_START;
        end else begin
          run     = run_add(run, KIND_NO_EQ, 8'h00);
          phase_d = PH_SKIP;
        end
      end
      PH_VAL_START: begin
        if (c == CH_QUOTE) begin
          phase_d = PH_QUOTED;
        end else if (c == CH_COMMA) begin
          run     = run_add(run, KIND_PAIR, 8'h00);
          phase_d = PH_NAME_START;
        end else begin
          run     = run_add(run, KIND_VALUE_CHAR, c);
          phase_d = PH_PLAIN;
        end
      end
      PH_PLAIN: begin
        if (c == CH_COMMA) begin
          run     = run_add(run, KIND_PAIR, 8'h00);
          phase_d = PH_NAME_START;
        end else begin
          run = run_add(run, KIND_VALUE_CHAR, c);
        end
      end
      PH_QUOTED: begin
        if (c == CH_QUOTE) begin
          run     = run_add(run, KIND_PAIR, 8'h00);
          phase_d = PH_AFTER_QUOTE;
        end else if (c == CH_BSLASH) begin
          phase_d = PH_ESCAPE;
        end else begin
          run = run_add(run, KIND_VALUE_CHAR, c);
        end
      end
      PH_ESCAPE: begin
        run     = run_add(run, KIND_VALUE_CHAR, esc_c);
        phase_d = PH_QUOTED;
      end
      PH_AFTER_QUOTE: begin
        if (c == CH_COMMA) begin
          phase_d = PH_NAME_START;
        end else begin
          run     = run_add(run, KIND_BAD_SEP, 8'h00);
          phase_d = PH_SKIP;
        end
      end
      PH_SKIP: begin
        phase_d = PH_SKIP;
      end
      default: begin
        phase_d = PH_SKIP;
      end
    endcase

    if (in_data_i.line_last) begin
      if (phase_d == PH_NAME) begin
        run = run_add(run, KIND_NO_EQ, 8'h00);
      end else if ((phase_d == PH_VAL_START) || (phase_d == PH_PLAIN) ||
                   (phase_d == PH_QUOTED) || (phase_d == PH_ESCAPE)) begin
        run = run_add(run, KIND_PAIR, 8'h00);
      end
      run     = run_add(run, KIND_LINE_END, 8'h00);
      phase_d = PH_NAME_START;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NAME_START;
    end else if (accept_i) begin
      phase_q <= phase_d;
    end
  end

  // bytes that cause no result never enter the queue
  assign run_push_o = accept_i && (run.cnt != '0);
  assign run_o      = run;

endmodule

// ----- sv/alp_queue.sv -----
// short run queue between front end and result sequencer
`include "assert_macros.svh"
module alp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  alp_pkg::q_ctrl_t ctrl_i,
  input  alp_pkg::run_t    wr_data_i,
  output alp_pkg::run_t    rd_data_o,
  output logic             full_o,
  output logic             empty_o
);
  import alp_pkg::*;

  run_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = ctrl_i.push && !full_o;
  assign do_pop  = ctrl_i.pop && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= QCNT_W'(QUEUE_DEPTH))
  `ASSERT_ALWAYS(a_no_push_full, clk_i, rst_ni, !(ctrl_i.push && full_o))
  `ASSERT_NEXT(a_push_fills, clk_i, rst_ni, do_push && !do_pop, !empty_o)

endmodule

// ----- sv/alp_back.sv -----
// back end: plays out each queued run one result beat at a time
`include "assert_macros.svh"
module alp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  alp_pkg::run_t q_data_i,
  input  logic          q_empty_i,
  output logic          q_pop_o,
  input  logic          pop,
  output logic          empty,
  output alp_pkg::out_t out_data_o
);
  import alp_pkg::*;

  run_t                 run_q;
  logic                 run_valid_q;
  logic [RUN_IDX_W-1:0] idx_q;
  logic                 last_beat;
  logic                 take;

  assign last_beat = (RUN_CNT_W'(idx_q) == (run_q.cnt - RUN_CNT_W'(1)));
  // load a new run when idle or when the last beat of this one leaves
  assign take    = !run_valid_q || (pop && last_beat);
  assign q_pop_o = take && !q_empty_i;

  assign empty               = !run_valid_q;
  assign out_data_o.kind     = run_q.kind[idx_q];
  assign out_data_o.char_out = run_q.chr[idx_q];
  assign out_data_o.run_end  = last_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (take) begin
      run_valid_q <= !q_empty_i;
      idx_q       <= '0;
    end else if (pop) begin
      idx_q <= idx_q + RUN_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      run_q <= q_data_i;
    end
  end

  `ASSERT_ALWAYS(a_run_nonempty, clk_i, rst_ni, !run_valid_q || (run_q.cnt != '0))
  `ASSERT_ALWAYS(a_idx_in_run, clk_i, rst_ni, !run_valid_q || (RUN_CNT_W'(idx_q) < run_q.cnt))

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the attribute list parser core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import alp_pkg::*;

  typedef enum logic [2:0] {
    P_NAME_START   = 3'd0,
    P_NAME         = 3'd1,
    P_VAL_START    = 3'd2,
    P_PLAIN        = 3'd3,
    P_QUOTED       = 3'd4,
    P_ESCAPE       = 3'd5,
    P_AFTER_QUOTE  = 3'd6,
    P_SKIP         = 3'd7
  } parse_phase_e;

  // one directed beat; n nonzero means the results are typed in below
  typedef struct packed {
    logic [7:0]     b;
    logic           last;
    logic [1:0]     n;
    out_t [2:0]     run;
  } row_t;

  localparam int DIR_ROWS = 26;
  localparam int RAND_PER_PHASE = 125;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  in_t  in_data = '0;
  out_t out_data;

  parse_phase_e parse_st = P_NAME_START;
  out_t         pending_results[$];
  logic [7:0]   line_bytes[$];
  int           errors = 0;
  int           send_idle = 0;
  int           rcv_stall = 0;
  out_t         want;
  row_t         dir_rows [DIR_ROWS];

  attribute_list_parser_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .pop        (pop),
    .empty      (empty),
    .out_data_o (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic out_t res(kind_e k, logic [7:0] c, logic e);
    out_t r;
    r.kind = k;
    r.char_out = c;
    r.run_end = e;
    return r;
  endfunction

  function automatic row_t row(logic [7:0] b, logic last = 1'b0, logic [1:0] n = 2'd0,
                               out_t r0 = '0, out_t r1 = '0, out_t r2 = '0);
    row_t t;
    t.b = b;
    t.last = last;
    t.n = n;
    t.run = {r2, r1, r0};
    return t;
  endfunction

  // results of one byte, advancing the parse phase
  task automatic parse_byte(input in_t it, output out_t [2:0] run, output int cnt);
    logic [7:0] c;
    logic       is_name;
    c = it.byte_in;
    is_name = (c >= CH_UP_A && c <= CH_UP_Z) || c == CH_DASH;
    run = '0;
    cnt = 0;
    case (parse_st)
      P_NAME_START, P_NAME: begin
        if (is_name) begin
          run[cnt] = res(KIND_NAME_CHAR, c, 1'b0);
          cnt++;
          parse_st = P_NAME;
        end else if (c == CH_EQ) begin
          parse_st = P_VAL_START;
        end else begin
          run[cnt] = res(KIND_NO_EQ, 8'h00, 1'b0);
          cnt++;
          parse_st = P_SKIP;
        end
      end
      P_VAL_START: begin
        if (c == CH_QUOTE) begin
          parse_st = P_QUOTED;
        end else if (c == CH_COMMA) begin
          run[cnt] = res(KIND_PAIR, 8'h00, 1'b0);
          cnt++;
          parse_st = P_NAME_START;
        end else begin
          run[cnt] = res(KIND_VALUE_CHAR, c, 1'b0);
          cnt++;
          parse_st = P_PLAIN;
        end
      end
      P_PLAIN: begin
        if (c == CH_COMMA) begin
          run[cnt] = res(KIND_PAIR, 8'h00, 1'b0);
          cnt++;
          parse_st = P_NAME_START;
        end else begin
          run[cnt] = res(KIND_VALUE_CHAR, c, 1'b0);
          cnt++;
        end
      end
      P_QUOTED: begin
        if (c == CH_QUOTE) begin
          run[cnt] = res(KIND_PAIR, 8'h00, 1'b0);
          cnt++;
          parse_st = P_AFTER_QUOTE;
        end else if (c == CH_BSLASH) begin
          parse_st = P_ESCAPE;
        end else begin
          run[cnt] = res(KIND_VALUE_CHAR, c, 1'b0);
          cnt++;
        end
      end
      P_ESCAPE: begin
        if (c == CH_LOW_R) c = CH_CR;
        else if (c == CH_LOW_N) c = CH_LF;
        run[cnt] = res(KIND_VALUE_CHAR, c, 1'b0);
        cnt++;
        parse_st = P_QUOTED;
      end
      P_AFTER_QUOTE: begin
        if (c == CH_COMMA) begin
          parse_st = P_NAME_START;
        end else begin
          run[cnt] = res(KIND_BAD_SEP, 8'h00, 1'b0);
          cnt++;
          parse_st = P_SKIP;
        end
      end
      default: ;
    endcase
    if (it.line_last) begin
      // a name left open or a value in progress is closed at the line end
      if (parse_st == P_NAME) begin
        run[cnt] = res(KIND_NO_EQ, 8'h00, 1'b0);
        cnt++;
      end else if (parse_st inside {P_VAL_START, P_PLAIN, P_QUOTED, P_ESCAPE}) begin
        run[cnt] = res(KIND_PAIR, 8'h00, 1'b0);
        cnt++;
      end
      run[cnt] = res(KIND_LINE_END, 8'h00, 1'b0);
      cnt++;
      parse_st = P_NAME_START;
    end
    if (cnt > 0) run[cnt-1].run_end = 1'b1;
  endtask

  // one input beat; expected results queued once the beat is taken
  task automatic send_byte(input in_t it, input logic [1:0] n_typed, input out_t [2:0] typed);
    out_t [2:0] run;
    int         cnt;
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (full);
    parse_byte(it, run, cnt);
    if (n_typed != 2'd0) begin
      run = typed;
      cnt = n_typed;
    end
    for (int k = 0; k < cnt; k++) pending_results.push_back(run[k]);
  endtask

  function automatic logic [7:0] name_char();
    int r;
    r = $urandom_range(0, 26);
    return (r == 26) ? CH_DASH : CH_UP_A + 8'(r);
  endfunction

  // mostly well-formed lines with random content, some broken ones and noise
  task automatic build_line();
    int         pairs;
    int         len;
    int         style;
    int         pick;
    logic [7:0] c;
    line_bytes.delete();
    style = $urandom_range(0, 9);
    if (style >= 8) begin
      len = $urandom_range(1, 8);
      repeat (len) line_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    pairs = $urandom_range(1, 3);
    for (int p = 0; p < pairs; p++) begin
      if (p > 0) line_bytes.push_back(CH_COMMA);
      len = $urandom_range(0, 4);
      repeat (len) line_bytes.push_back(name_char());
      line_bytes.push_back(CH_EQ);
      len = $urandom_range(0, 4);
      if ($urandom_range(0, 2) == 0) begin
        repeat (len) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_COMMA);
          line_bytes.push_back(c);
        end
      end else begin
        line_bytes.push_back(CH_QUOTE);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) begin
            line_bytes.push_back(CH_BSLASH);
            pick = $urandom_range(0, 4);
            case (pick)
              0: c = CH_LOW_R;
              1: c = CH_LOW_N;
              2: c = CH_QUOTE;
              3: c = CH_BSLASH;
              default: c = 8'($urandom_range(0, 255));
            endcase
          end else begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
          end
          line_bytes.push_back(c);
        end
        // an open quote now and then on the final pair
        if (p != pairs - 1 || $urandom_range(0, 7) != 0) line_bytes.push_back(CH_QUOTE);
      end
    end
    if ($urandom_range(0, 7) == 0) line_bytes.push_back(CH_COMMA);
    if (style == 7) line_bytes[$urandom_range(0, line_bytes.size() - 1)] =
                    8'($urandom_range(0, 255));
  endtask

  // result side: check every beat, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: kind %0d char %0h run_end %0d",
               out_data.kind, out_data.char_out, out_data.run_end);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.kind != want.kind) begin
          $error("kind: expected %0d actual %0d", want.kind, out_data.kind);
          errors++;
        end
        if (out_data.char_out != want.char_out) begin
          $error("char_out: expected %0h actual %0h", want.char_out, out_data.char_out);
          errors++;
        end
        if (out_data.run_end != want.run_end) begin
          $error("run_end: expected %0d actual %0d", want.run_end, out_data.run_end);
          errors++;
        end
      end
    end
    pop <= ($urandom_range(0, 99) >= rcv_stall);
  end

  initial begin
    in_t it;
    int  sent;
    int  idle_pct [4];
    int  stall_pct [4];
    idle_pct = '{0, 77, 0, 20};
    stall_pct = '{0, 0, 77, 20};
    dir_rows = '{
      row(CH_UP_A, 1'b0, 2'd1, res(KIND_NAME_CHAR, CH_UP_A, 1'b1)),
      row(CH_UP_Z),
      row(CH_DASH),
      row(CH_EQ),
      row(8'hFF, 1'b0, 2'd1, res(KIND_VALUE_CHAR, 8'hFF, 1'b1)),
      row(CH_COMMA),
      row(CH_EQ),                        // empty name
      row(CH_QUOTE),
      row(CH_BSLASH),
      row(CH_LOW_R, 1'b0, 2'd1, res(KIND_VALUE_CHAR, CH_CR, 1'b1)),
      row(CH_BSLASH),
      row(CH_LOW_N),
      row(CH_BSLASH),
      row(8'h00),                        // escaped byte stands for itself
      row(CH_QUOTE),
      row("q", 1'b0, 2'd1, res(KIND_BAD_SEP, 8'h00, 1'b1)),
      row(8'hFF, 1'b1, 2'd1, res(KIND_LINE_END, 8'h00, 1'b1)),
      // name cut short by the line end
      row("C", 1'b1, 2'd3, res(KIND_NAME_CHAR, "C", 1'b0), res(KIND_NO_EQ, 8'h00, 1'b0),
          res(KIND_LINE_END, 8'h00, 1'b1)),
      row(8'h00, 1'b0, 2'd1, res(KIND_NO_EQ, 8'h00, 1'b1)),
      row(CH_COMMA, 1'b1, 2'd1, res(KIND_LINE_END, 8'h00, 1'b1)),
      row(CH_EQ),
      row(CH_COMMA, 1'b1),               // empty value, then trailing comma
      row(CH_EQ, 1'b1),                  // empty value at line end
      row(CH_EQ),
      row(CH_QUOTE),
      row(CH_BSLASH, 1'b1)               // open quote, backslash dropped
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      it.byte_in = dir_rows[i].b;
      it.line_last = dir_rows[i].last;
      send_byte(it, dir_rows[i].n, dir_rows[i].run);
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle = idle_pct[ph];
      rcv_stall = stall_pct[ph];
      sent = 0;
      while (sent < RAND_PER_PHASE) begin
        build_line();
        foreach (line_bytes[i]) begin
          it.byte_in = line_bytes[i];
          it.line_last = (i == line_bytes.size() - 1);
          send_byte(it, 2'd0, '0);
          sent++;
        end
      end
    end

    push <= 1'b0;
    rcv_stall = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // stray results would show up during this wait
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
